// File: sv/mjq_pkg.sv
// Shared constants, types and helpers of the minimum-jerk quintic coefficient block.
package mjq_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int DUR_W          = 23;
	localparam int MUL_CHUNK      = 32;
	localparam int QUEUE_DEPTH    = 4;

	typedef struct packed {
		logic empty;
		logic full;
	} mjq_qstat_t;

	// width of one classified request held in the queue
	function automatic int item_w(input int dw);
		return 12 * dw + 54 + DUR_W;
	endfunction

endpackage

// File: sv/min_jerk_quintic_coeffs.sv
// Top level of the minimum-jerk quintic coefficient block.
//
// Input channel (in_valid / in_stall): one request carries the start and end
// position, velocity and acceleration in signed fixed point plus the duration.
// A zero duration is taken as one LSB. Output channel (out_valid / out_stall):
// one result per request, coef0..coef5 and status, in request order; status is
// set when any of coef3..coef5 had to be clamped.
// Throughput: one request per cycle while in_stall is low. The front part
// classifies a request into a four-entry queue; the back part is a single
// pipeline that advances whenever its output register is empty or being
// taken. The back pipeline holds the three bit-per-stage dividers,
// DATA_WIDTH + 3 stages deep, behind eight stages of duration products.
// When out_stall is held with a result present, the back pipeline freezes
// with its result held; the queue then fills and in_stall rises once it
// holds four requests.
// Reset empties the queue and the pipeline; nothing else needs clearing.
module min_jerk_quintic_coeffs #(
	parameter int DATA_WIDTH = mjq_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = mjq_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [DATA_WIDTH-1:0]  start_pos,
	input  logic signed [DATA_WIDTH-1:0]  start_vel,
	input  logic signed [DATA_WIDTH-1:0]  start_acc,
	input  logic signed [DATA_WIDTH-1:0]  end_pos,
	input  logic signed [DATA_WIDTH-1:0]  end_vel,
	input  logic signed [DATA_WIDTH-1:0]  end_acc,
	input  logic [mjq_pkg::DUR_W-1:0]     duration,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [DATA_WIDTH-1:0]  coef0,
	output logic signed [DATA_WIDTH-1:0]  coef1,
	output logic signed [DATA_WIDTH-1:0]  coef2,
	output logic signed [DATA_WIDTH-1:0]  coef3,
	output logic signed [DATA_WIDTH-1:0]  coef4,
	output logic signed [DATA_WIDTH-1:0]  coef5,
	output logic                          status
);
	import mjq_pkg::*;

	localparam int IW = item_w(DATA_WIDTH);

	logic          push, pop;
	logic [IW-1:0] item_in, item_out;
	mjq_qstat_t    qstat;

	mjq_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.start_pos(start_pos),
		.start_vel(start_vel),
		.start_acc(start_acc),
		.end_pos  (end_pos),
		.end_vel  (end_vel),
		.end_acc  (end_acc),
		.duration (duration),
		.qstat    (qstat),
		.push     (push),
		.item     (item_in)
	);

	mjq_fifo #(.W(IW), .DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (item_in),
		.pop   (pop),
		.dout  (item_out),
		.qstat (qstat)
	);

	mjq_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.qstat    (qstat),
		.item     (item_out),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.coef0    (coef0),
		.coef1    (coef1),
		.coef2    (coef2),
		.coef3    (coef3),
		.coef4    (coef4),
		.coef5    (coef5),
		.status   (status)
	);

endmodule

// File: sv/mjq_fifo.sv
// Short register queue between the front and back parts.
module mjq_fifo #(
	parameter int W     = 32,
	parameter int DEPTH = mjq_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [W-1:0]        din,
	input  logic                pop,
	output logic [W-1:0]        dout,
	output mjq_pkg::mjq_qstat_t qstat
);
	import mjq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign qstat.empty = (cnt_q == '0);
	assign qstat.full  = (cnt_q == CW'(DEPTH));
	assign dout        = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// File: sv/mjq_front.sv
// Front part: accepts a request, forms the boundary residual combinations and queues them.
module mjq_front #(
	parameter int DATA_WIDTH = mjq_pkg::DATA_WIDTH_DEF
) (
	input  logic                                       in_valid,
	output logic                                       in_stall,
	input  logic signed [DATA_WIDTH-1:0]               start_pos,
	input  logic signed [DATA_WIDTH-1:0]               start_vel,
	input  logic signed [DATA_WIDTH-1:0]               start_acc,
	input  logic signed [DATA_WIDTH-1:0]               end_pos,
	input  logic signed [DATA_WIDTH-1:0]               end_vel,
	input  logic signed [DATA_WIDTH-1:0]               end_acc,
	input  logic [mjq_pkg::DUR_W-1:0]                  duration,
	input  mjq_pkg::mjq_qstat_t                        qstat,
	output logic                                       push,
	output logic [mjq_pkg::item_w(DATA_WIDTH)-1:0]     item
);
	import mjq_pkg::*;

	localparam int DW = DATA_WIDTH;
	localparam int LW = DW + 6;
	localparam int TW = DUR_W;

	logic signed [LW-1:0] s1x, s2x, e1x, e2x, dpx;
	logic signed [LW-1:0] pc [3];
	logic signed [LW-1:0] vc [3];
	logic signed [LW-1:0] ac [3];
	logic signed [DW:0]   half;
	logic [TW-1:0]        tx;

	assign in_stall = qstat.full;
	assign push     = in_valid && !qstat.full;

	always_comb begin
		s1x = LW'(start_vel);
		s2x = LW'(start_acc);
		e1x = LW'(end_vel);
		e2x = LW'(end_acc);
		dpx = LW'(end_pos) - LW'(start_pos);

		pc[0] = dpx * LW'(20);
		vc[0] = -(e1x * LW'(8) + s1x * LW'(12));
		ac[0] = e2x - s2x * LW'(3);

		pc[1] = -(dpx * LW'(30));
		vc[1] = e1x * LW'(14) + s1x * LW'(16);
		ac[1] = s2x * LW'(3) - e2x * LW'(2);

		pc[2] = dpx * LW'(12);
		vc[2] = -((e1x + s1x) * LW'(6));
		ac[2] = e2x - s2x;

		// halve, ties away from zero
		half = (DW + 1)'(start_acc) + (DW + 1)'(!start_acc[DW-1]);
		tx   = (duration == '0) ? TW'(1) : duration;

		item = '0;
		for (int k = 0; k < 3; k++) begin
			item[k*LW +: LW]       = ac[k];
			item[(3+k)*LW +: LW]   = vc[k];
			item[(6+k)*LW +: LW]   = pc[k];
		end
		item[9*LW +: TW]              = tx;
		item[9*LW+TW +: DW]           = half[DW:1];
		item[9*LW+TW+DW +: DW]        = start_vel;
		item[9*LW+TW+2*DW +: DW]      = start_pos;
	end

endmodule

// File: sv/mjq_mul.sv
// Two-stage multiply of a wide signed operand by the duration, with an addend.
module mjq_mul #(
	parameter int AW = 24,
	parameter int OW = 47
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [AW-1:0]         a,
	input  logic [mjq_pkg::DUR_W-1:0]    t,
	input  logic signed [OW-1:0]         c,
	output logic signed [OW-1:0]         p
);
	import mjq_pkg::*;

	localparam int CK = MUL_CHUNK;
	localparam int NC = (AW + CK - 1) / CK;
	localparam int XW = NC * CK;
	localparam int PW = CK + DUR_W + 2;

	logic signed [XW-1:0] ax;
	logic signed [PW-1:0] pp_s1 [NC];
	logic signed [OW-1:0] c_s1;
	logic signed [OW-1:0] acc;
	logic signed [OW-1:0] p_s2;

	assign ax = XW'(a);
	assign p  = p_s2;

	for (genvar i = 0; i < NC; i++) begin : g_pp
		logic signed [CK:0] ch;
		if (i == NC - 1) begin : g_top
			assign ch = {ax[XW-1], ax[i*CK +: CK]};
		end else begin : g_low
			assign ch = {1'b0, ax[i*CK +: CK]};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				pp_s1[i] <= ch * $signed({1'b0, t});
			end
		end
	end

	always_comb begin
		acc = c_s1;
		for (int i = 0; i < NC; i++) begin
			acc = acc + (OW'(pp_s1[i]) <<< (CK * i));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1 <= c;
			p_s2 <= acc;
		end
	end

endmodule

// File: sv/mjq_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
module mjq_div #(
	parameter int NUMW = 64,
	parameter int DENW = 32,
	parameter int QB   = 34
) (
	input  logic            clk,
	input  logic            en,
	input  logic [NUMW-1:0] num,
	input  logic [DENW-1:0] den,
	output logic [QB-1:0]   quo,
	output logic            ovf
);
	localparam int CW = ((NUMW > DENW + QB) ? NUMW : DENW + QB) + 1;

	logic [CW-1:0]   r_s [QB+1];
	logic [DENW-1:0] d_s [QB+1];
	logic [QB-1:0]   q_s [QB+1];
	logic            o_s [QB+1];

	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0] <= CW'(num);
			d_s[0] <= den;
			q_s[0] <= '0;
			o_s[0] <= 1'b0;
		end
	end

	for (genvar i = 1; i <= QB; i++) begin : g_stage
		localparam int J = QB - i;
		logic [CW-1:0] sh;
		logic          ge;
		assign sh = CW'(d_s[i-1]) << J;
		assign ge = (r_s[i-1] >= sh);
		always_ff @(posedge clk) begin
			if (en) begin
				r_s[i] <= ge ? (r_s[i-1] - sh) : r_s[i-1];
				d_s[i] <= d_s[i-1];
				q_s[i] <= q_s[i-1] | (QB'(ge) << J);
				if (i == 1) begin
					o_s[i] <= (r_s[0] >= (CW'(d_s[0]) << QB));
				end else begin
					o_s[i] <= o_s[i-1];
				end
			end
		end
	end

	assign quo = q_s[QB];
	assign ovf = o_s[QB];

endmodule

// File: sv/mjq_back.sv
// Back part: Horner numerators, duration powers, three dividers, rounding and saturation.
module mjq_back #(
	parameter int DATA_WIDTH = mjq_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = mjq_pkg::FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  mjq_pkg::mjq_qstat_t                    qstat,
	input  logic [mjq_pkg::item_w(DATA_WIDTH)-1:0] item,
	output logic                                   pop,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [DATA_WIDTH-1:0]           coef0,
	output logic signed [DATA_WIDTH-1:0]           coef1,
	output logic signed [DATA_WIDTH-1:0]           coef2,
	output logic signed [DATA_WIDTH-1:0]           coef3,
	output logic signed [DATA_WIDTH-1:0]           coef4,
	output logic signed [DATA_WIDTH-1:0]           coef5,
	output logic                                   status
);
	import mjq_pkg::*;

	localparam int DW = DATA_WIDTH;
	localparam int FB = FRAC_BITS;
	localparam int TW = DUR_W;
	localparam int LW = DW + 6;
	localparam int HW = DW + 30 + FB;
	localparam int NW = HW + 24;
	localparam int QB = DW + 2;
	localparam int L  = QB + 10;

	logic           adv;
	logic [L-1:0]   vld_q;
	logic [TW-1:0]  t_in;
	logic [TW-1:0]  td_q [6];
	logic [3*DW-1:0] c_q [L];
	logic signed [2*TW:0] t2;
	logic signed [3*TW:0] t3;
	logic signed [4*TW:0] t4;
	logic signed [5*TW:0] t5;
	logic [3*TW-1:0] t3d_q [4];
	logic [4*TW-1:0] t4d_q [2];
	logic signed [DW-1:0] fin_q [3];
	logic                 sat_q [3];

	assign out_valid = vld_q[L-1];
	assign adv       = !out_valid || !out_stall;
	assign pop       = adv && !qstat.empty;
	assign t_in      = item[9*LW +: TW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[L-2:0], !qstat.empty};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			td_q[0] <= t_in;
			for (int i = 1; i < 6; i++) td_q[i] <= td_q[i-1];
			c_q[0] <= item[9*LW+TW +: 3*DW];
			for (int i = 1; i < L; i++) c_q[i] <= c_q[i-1];
			t3d_q[0] <= t3[3*TW-1:0];
			for (int i = 1; i < 4; i++) t3d_q[i] <= t3d_q[i-1];
			t4d_q[0] <= t4[4*TW-1:0];
			t4d_q[1] <= t4d_q[0];
		end
	end

	mjq_mul #(.AW(TW + 1), .OW(2*TW + 1)) u_t2 (
		.clk(clk), .en(adv), .a({1'b0, t_in}), .t(t_in), .c('0), .p(t2)
	);
	mjq_mul #(.AW(2*TW + 1), .OW(3*TW + 1)) u_t3 (
		.clk(clk), .en(adv), .a(t2), .t(td_q[1]), .c('0), .p(t3)
	);
	mjq_mul #(.AW(3*TW + 1), .OW(4*TW + 1)) u_t4 (
		.clk(clk), .en(adv), .a(t3), .t(td_q[3]), .c('0), .p(t4)
	);
	mjq_mul #(.AW(4*TW + 1), .OW(5*TW + 1)) u_t5 (
		.clk(clk), .en(adv), .a(t4), .t(td_q[5]), .c('0), .p(t5)
	);

	for (genvar k = 0; k < 3; k++) begin : g_lane
		localparam int DENW = TW * (k + 3);
		localparam int NUMW = NW + (k + 1) * FB;

		logic signed [LW-1:0] a_in, v_in, p_in;
		logic signed [LW-1:0] pd_q [2];
		logic signed [HW-1:0] h1;
		logic signed [NW-1:0] n;
		logic [NW-1:0]        mag_s5;
		logic                 neg_s5;
		logic [NW-1:0]        magd_q [3];
		logic                 negd_q [QB+4];
		logic [DENW-1:0]      den;
		logic [NUMW-1:0]      num;
		logic [QB-1:0]        quo;
		logic                 ovf;
		logic [QB:0]          rnd;
		logic                 negf, sat;
		logic signed [DW-1:0] val;

		assign a_in = item[k*LW +: LW];
		assign v_in = item[(3+k)*LW +: LW];
		assign p_in = item[(6+k)*LW +: LW];

		mjq_mul #(.AW(LW), .OW(HW)) u_ha (
			.clk(clk), .en(adv), .a(a_in), .t(t_in),
			.c(HW'(v_in) <<< FB), .p(h1)
		);
		mjq_mul #(.AW(HW), .OW(NW)) u_hb (
			.clk(clk), .en(adv), .a(h1), .t(td_q[1]),
			.c(NW'(pd_q[1]) <<< (2*FB)), .p(n)
		);

		always_ff @(posedge clk) begin
			if (adv) begin
				pd_q[0] <= p_in;
				pd_q[1] <= pd_q[0];
				neg_s5  <= n[NW-1];
				mag_s5  <= n[NW-1] ? NW'(-n) : NW'(n);
				magd_q[0] <= mag_s5;
				magd_q[1] <= magd_q[0];
				magd_q[2] <= magd_q[1];
				negd_q[0] <= neg_s5;
				for (int i = 1; i < QB + 4; i++) negd_q[i] <= negd_q[i-1];
			end
		end

		if (k == 0) begin : g_d3
			assign den = t3d_q[3];
		end else if (k == 1) begin : g_d4
			assign den = t4d_q[1];
		end else begin : g_d5
			assign den = t5[5*TW-1:0];
		end

		assign num = NUMW'(magd_q[2]) << ((k + 1) * FB);

		mjq_div #(.NUMW(NUMW), .DENW(DENW), .QB(QB)) u_div (
			.clk(clk), .en(adv), .num(num), .den(den), .quo(quo), .ovf(ovf)
		);

		// quotient carries one extra fraction bit: round half away from zero
		always_comb begin
			negf = negd_q[QB+3];
			rnd  = ((QB + 1)'(quo) + (QB + 1)'(1)) >> 1;
			if (negf) begin
				sat = ovf || (rnd > ((QB + 1)'(1) << (DW - 1)));
			end else begin
				sat = ovf || (rnd > (((QB + 1)'(1) << (DW - 1)) - (QB + 1)'(1)));
			end
			if (sat) begin
				val = negf ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
			end else begin
				val = negf ? -rnd[DW-1:0] : rnd[DW-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				fin_q[k] <= val;
				sat_q[k] <= sat;
			end
		end
	end

	assign coef0  = c_q[L-1][2*DW +: DW];
	assign coef1  = c_q[L-1][DW +: DW];
	assign coef2  = c_q[L-1][0 +: DW];
	assign coef3  = fin_q[0];
	assign coef4  = fin_q[1];
	assign coef5  = fin_q[2];
	assign status = sat_q[0] || sat_q[1] || sat_q[2];

endmodule

// File: sv/mjq_chk.sv
// Port-level checker for the coefficient block, bound to the top level.
module mjq_chk #(
	parameter int DATA_WIDTH = mjq_pkg::DATA_WIDTH_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic signed [DATA_WIDTH-1:0] coef3,
	input logic signed [DATA_WIDTH-1:0] coef4,
	input logic signed [DATA_WIDTH-1:0] coef5,
	input logic                         status
);
	localparam logic signed [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(coef3) && $stable(coef4) && $stable(coef5)
			&& $stable(status))
		else $error("result changed while stalled");

	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> (coef3 == MAXV || coef3 == MINV || coef4 == MAXV
			|| coef4 == MINV || coef5 == MAXV || coef5 == MINV))
		else $error("status set without a clamped coefficient");

	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result present straight after reset");

endmodule

bind min_jerk_quintic_coeffs mjq_chk #(.DATA_WIDTH(DATA_WIDTH)) u_mjq_chk (.*);

// File: sim/tb_min_jerk_quintic_coeffs.sv
// Self-checking testbench for the minimum-jerk quintic coefficient block.
`timescale 1ns / 100ps

module tb_min_jerk_quintic_coeffs;

	localparam int DW        = mjq_pkg::DATA_WIDTH_DEF;
	localparam int FB        = mjq_pkg::FRAC_BITS_DEF;
	localparam int TW        = mjq_pkg::DUR_W;
	localparam int LATENCY   = DW + 13;
	localparam int MAX_CYCLE = 400000;
	localparam int HOLD_CYCLES = 200;

	typedef struct {
		logic signed [DW-1:0] sp, sv, sa, ep, ev, ea;
		logic [TW-1:0]        dur;
	} request_t;

	typedef struct {
		logic signed [DW-1:0] c0, c1, c2, c3, c4, c5;
		logic                 st;
	} coeffs_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [DW-1:0] start_pos = '0, start_vel = '0, start_acc = '0;
	logic signed [DW-1:0] end_pos = '0, end_vel = '0, end_acc = '0;
	logic [TW-1:0] duration = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [DW-1:0] coef0, coef1, coef2, coef3, coef4, coef5;
	logic status;

	coeffs_t pending_coeffs[$];
	int errors = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_sat = 0;
	int cycles = 0;
	int rx_wait = 0;
	int long_hold = 0;
	bit no_idle = 0;
	bit hold_start = 0;
	bit hold_taken = 0;

	min_jerk_quintic_coeffs dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.start_pos(start_pos), .start_vel(start_vel), .start_acc(start_acc),
		.end_pos(end_pos), .end_vel(end_vel), .end_acc(end_acc),
		.duration(duration),
		.out_valid(out_valid), .out_stall(out_stall),
		.coef0(coef0), .coef1(coef1), .coef2(coef2), .coef3(coef3),
		.coef4(coef4), .coef5(coef5), .status(status)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int rand_gap();
		return no_idle ? 0 : $urandom_range(0, 4);
	endfunction

	// round to nearest, ties away from zero, then clamp
	function automatic logic [DW-1:0] round_clamp(logic signed [255:0] num,
			logic [255:0] den, inout logic sat);
		logic neg;
		logic [255:0] mag, q, rem, lim;
		neg = num < 0;
		mag = neg ? -num : num;
		q = mag / den;
		rem = mag - q * den;
		if ((rem << 1) >= den) q = q + 1;
		lim = neg ? (256'd1 << (DW - 1)) : (256'd1 << (DW - 1)) - 1;
		if (q > lim) begin
			q = lim;
			sat = 1'b1;
		end
		if (neg) q = -q;
		return q[DW-1:0];
	endfunction

	function automatic coeffs_t quintic_fit(request_t r);
		coeffs_t c;
		logic signed [255:0] s0, s1, s2, e1, e2, dp, t, pp, vv, aa, n;
		logic [255:0] t3;
		logic signed [DW:0] x, h;
		logic sat;
		sat = 1'b0;
		s0 = 256'(r.sp); s1 = 256'(r.sv); s2 = 256'(r.sa);
		e1 = 256'(r.ev); e2 = 256'(r.ea);
		dp = 256'(r.ep);
		dp = dp - s0;
		t = {233'b0, (r.dur == 0) ? 23'd1 : r.dur};
		t3 = 2 * t * t * t;
		c.c0 = r.sp;
		c.c1 = r.sv;
		x = (DW + 1)'(r.sa);
		if (x < 0) begin
			h = (-x + 1) >>> 1;
			c.c2 = DW'(-h);
		end else begin
			c.c2 = DW'((x + 1) >>> 1);
		end
		pp = 20 * dp; vv = -(8 * e1 + 12 * s1); aa = e2 - 3 * s2;
		n = (pp <<< (2 * FB)) + ((vv * t) <<< FB) + aa * t * t;
		c.c3 = round_clamp(n <<< FB, t3, sat);
		pp = -30 * dp; vv = 14 * e1 + 16 * s1; aa = 3 * s2 - 2 * e2;
		n = (pp <<< (2 * FB)) + ((vv * t) <<< FB) + aa * t * t;
		c.c4 = round_clamp(n <<< (2 * FB), t3 * t, sat);
		pp = 12 * dp; vv = -6 * (e1 + s1); aa = e2 - s2;
		n = (pp <<< (2 * FB)) + ((vv * t) <<< FB) + aa * t * t;
		c.c5 = round_clamp(n <<< (3 * FB), t3 * t * t, sat);
		c.st = sat;
		return c;
	endfunction

	// leaves in_valid high so back-to-back requests need no second assignment
	task automatic send_request(request_t r);
		int gap;
		gap = rand_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start_pos <= r.sp; start_vel <= r.sv; start_acc <= r.sa;
		end_pos <= r.ep; end_vel <= r.ev; end_acc <= r.ea;
		duration <= r.dur;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_coeffs = {pending_coeffs, quintic_fit(r)};
		n_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_coeffs.size() != 0) @(posedge clk);
	endtask

	function automatic logic signed [DW-1:0] rand_value();
		logic signed [DW-1:0] v;
		v = DW'($urandom);
		case ($urandom_range(0, 3))
			0: return v;
			default: return v >>> $urandom_range(8, 31);
		endcase
	endfunction

	function automatic logic [TW-1:0] rand_duration();
		case ($urandom_range(0, 9))
			0: return TW'($urandom);
			1: return TW'($urandom_range(0, 3));
			2: return TW'({TW{1'b1}} - $urandom_range(0, 3));
			default: return TW'($urandom_range(1 << 14, 1 << 20));
		endcase
	endfunction

	function automatic request_t rand_request();
		request_t r;
		r.sp = rand_value(); r.sv = rand_value(); r.sa = rand_value();
		r.ep = rand_value(); r.ev = rand_value(); r.ea = rand_value();
		r.dur = rand_duration();
		return r;
	endfunction

	// checker and receiver idling
	always @(posedge clk) begin
		coeffs_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				n_checked++;
				if (pending_coeffs.size() == 0) begin
					$error("result with no request outstanding");
					errors++;
				end else begin
					e = pending_coeffs.pop_front();
					if (e.st) n_sat++;
					if (coef0 !== e.c0) begin
						$error("coef0 exp %h got %h", e.c0, coef0); errors++;
					end
					if (coef1 !== e.c1) begin
						$error("coef1 exp %h got %h", e.c1, coef1); errors++;
					end
					if (coef2 !== e.c2) begin
						$error("coef2 exp %h got %h", e.c2, coef2); errors++;
					end
					if (coef3 !== e.c3) begin
						$error("coef3 exp %h got %h", e.c3, coef3); errors++;
					end
					if (coef4 !== e.c4) begin
						$error("coef4 exp %h got %h", e.c4, coef4); errors++;
					end
					if (coef5 !== e.c5) begin
						$error("coef5 exp %h got %h", e.c5, coef5); errors++;
					end
					if (status !== e.st) begin
						$error("status exp %b got %b", e.st, status); errors++;
					end
				end
			end
			if (hold_start && !hold_taken) begin
				hold_taken = 1'b1;
				long_hold = HOLD_CYCLES;
			end
			if (long_hold > 0) begin
				long_hold--;
				out_stall <= 1'b1;
			end else if (out_valid && !out_stall) begin
				rx_wait = rand_gap();
				out_stall <= rx_wait != 0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				out_stall <= rx_wait != 0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYCLE) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic test_directed();
		request_t r;
		logic signed [DW-1:0] mx, mn;
		mx = {1'b0, {DW-1{1'b1}}};
		mn = {1'b1, {DW-1{1'b0}}};
		r = '{mx, mx, mx, mx, mx, mx, 23'd65536};              send_request(r);
		r = '{mn, mn, mn, mn, mn, mn, 23'd65536};              send_request(r);
		r = '{mn, mx, mn, mx, mn, mx, 23'd1};                  send_request(r);
		r = '{mx, mn, mx, mn, mx, mn, {TW{1'b1}}};             send_request(r);
		r = '{0, 0, 0, 65536, 0, 0, 23'd0};                    send_request(r);
		r = '{0, 0, 0, 65536, 0, 0, 23'd4194304};              send_request(r);
		r = '{0, 0, 0, 0, 0, 0, 23'd65536};                    send_request(r);
		r = '{0, 0, 1, 0, 0, 0, 23'd65536};                    send_request(r);
		r = '{0, 0, -1, 0, 0, 0, 23'd65536};                   send_request(r);
		r = '{0, 0, -3, 0, 0, 0, 23'd65536};                   send_request(r);
		r = '{-65536, 65536, 0, 65536, 0, 0, 23'd131072};      send_request(r);
		r = '{0, 0, 0, 10 << 16, 0, 0, 23'd2 << 16};           send_request(r);
		r = '{0, 3 << 16, -2 << 16, 5 << 16, -1 << 16, 1 << 16, 23'd3 << 16};
		send_request(r);
		r = '{mx, 0, 0, mn, 0, 0, 23'd1};                      send_request(r);
		r = '{0, 0, 0, 1, 0, 0, 23'd0};                        send_request(r);
		r = '{12345, -777, 99, -54321, 4242, -31, {TW{1'b1}}}; send_request(r);
		wait_drained();
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++) begin
			no_idle = (i % 200) >= 150;
			send_request(rand_request());
		end
		no_idle = 0;
		wait_drained();
	endtask

	task automatic test_long_hold();
		hold_start = 1'b1;
		for (int i = 0; i < 60; i++) send_request(rand_request());
		wait_drained();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(800);
		test_long_hold();
		test_random(750);
		repeat (LATENCY + 20) @(posedge clk);
		$display("%0d requests sent, %0d results checked, %0d saturated",
			n_sent, n_checked, n_sat);
		$display("covered field extremes, zero and full-scale durations, stalls");
		if (errors == 0 && pending_coeffs.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// File: filelist.f
sv/mjq_pkg.sv
sv/mjq_fifo.sv
sv/mjq_front.sv
sv/mjq_mul.sv
sv/mjq_div.sv
sv/mjq_back.sv
sv/min_jerk_quintic_coeffs.sv
sv/mjq_chk.sv
sim/tb_min_jerk_quintic_coeffs.sv
